@@ src/s256_pkg.sv @@
package s256_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam logic [7:0]  PAD_MARK    = 8'h80;
    localparam logic [5:0]  LEN_OFFSET  = 6'd56;
    localparam logic [5:0]  LAST_BYTE   = 6'd63;
    localparam logic [5:0]  LAST_ROUND  = 6'd63;
    localparam logic [2:0]  LAST_WORD   = 3'd7;
    localparam logic        KIND_DATA   = 1'b0;
    localparam logic        KIND_FINISH = 1'b1;

    typedef logic [31:0] t_word;
    typedef logic [7:0][31:0] t_chain;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic   load;
        t_chain words;
    } t_dig_xfer;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_s0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_s1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_s0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_s1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word iv_word(input logic [2:0] idx);
        t_word r;
        case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic t_word k_const(input logic [5:0] idx);
        t_word r;
        case (idx)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;
            default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

@@ src/s256_front.sv @@
module s256_front #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  s256_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_take,
    output s256_pkg::t_item o_item
);
    import s256_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_put;
    logic          w_get;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_put   = i_push && !o_full;
    assign w_get   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_put) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_get) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (w_put && !w_get) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_get && !w_put) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ src/s256_back.sv @@
module s256_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  s256_pkg::t_item   i_item,
    output logic              o_take,
    input  logic              i_dq_busy,
    output s256_pkg::t_dig_xfer o_xfer
);
    import s256_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_LEN  = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]   r_state;
    logic [2:0]   r_ret;
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;
    logic [2:0]   r_len_cnt;
    logic [5:0]   r_rnd;
    logic [511:0] r_win;
    t_word        r_h [8];
    t_word        r_v [8];

    logic         w_shift;
    logic [7:0]   w_byte;
    logic         w_load;
    t_word        w_w0;
    t_word        w_wnew;
    t_word        w_t1;
    t_word        w_t2;
    t_word        w_ch;
    t_word        w_maj;

    // Message schedule window: the oldest word sits at the top tap; the taps below feed the next schedule word
    assign w_w0   = r_win[511 -: 32];
    assign w_wnew = small_s1(r_win[511 - 32*14 -: 32]) + r_win[511 - 32*9 -: 32]
                  + small_s0(r_win[511 - 32*1 -: 32]) + w_w0;

    assign w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t1  = r_v[7] + big_s1(r_v[4]) + w_ch + k_const(r_rnd) + w_w0;
    assign w_t2  = big_s0(r_v[0]) + w_maj;

    assign o_take = (r_state == ST_IDLE);
    assign w_load = (r_state == ST_EMIT) && !i_dq_busy;

    always_comb begin
        w_shift = 1'b0;
        w_byte  = 8'h00;
        case (r_state)
            ST_IDLE: begin
                w_shift = i_valid;
                w_byte  = (i_item.kind == KIND_FINISH) ? PAD_MARK : i_item.data_byte;
            end
            ST_PAD: begin
                w_shift = (r_fill != LEN_OFFSET);
            end
            ST_LEN: begin
                w_shift = 1'b1;
                w_byte  = r_bits[{~r_len_cnt, 3'b000} +: 8];
            end
            default: begin
                w_shift = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_xfer.load = w_load;
        for (int i = 0; i < 8; i++) begin
            o_xfer.words[i] = r_h[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_win <= {r_win[503:0], w_byte};
        end else if (r_state == ST_RND) begin
            r_win <= {r_win[479:0], w_wnew};
        end
        if (r_state == ST_RND) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end else if (w_shift && r_fill == LAST_BYTE) begin
            // load the working variables as the block completes
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ret     <= ST_IDLE;
            r_fill    <= '0;
            r_bits    <= '0;
            r_len_cnt <= '0;
            r_rnd     <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= iv_word(3'(i));
            end
        end else begin
            if (w_shift) begin
                r_fill <= r_fill + 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        if (i_item.kind == KIND_DATA) begin
                            r_bits <= r_bits + 64'd8;
                            r_ret  <= ST_IDLE;
                            if (r_fill == LAST_BYTE) begin
                                r_state <= ST_RND;
                                r_rnd   <= '0;
                            end
                        end else begin
                            r_ret <= ST_PAD;
                            if (r_fill == LAST_BYTE) begin
                                r_state <= ST_RND;
                                r_rnd   <= '0;
                            end else begin
                                r_state <= ST_PAD;
                            end
                        end
                    end
                end
                ST_PAD: begin
                    if (r_fill == LEN_OFFSET) begin
                        r_state   <= ST_LEN;
                        r_len_cnt <= '0;
                    end else if (r_fill == LAST_BYTE) begin
                        r_state <= ST_RND;
                        r_rnd   <= '0;
                        r_ret   <= ST_PAD;
                    end
                end
                ST_LEN: begin
                    r_len_cnt <= r_len_cnt + 1'b1;
                    if (r_len_cnt == LAST_WORD) begin
                        r_state <= ST_RND;
                        r_rnd   <= '0;
                        r_ret   <= ST_EMIT;
                    end
                end
                ST_RND: begin
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == LAST_ROUND) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_state <= r_ret;
                end
                ST_EMIT: begin
                    if (w_load) begin
                        for (int i = 0; i < 8; i++) begin
                            r_h[i] <= iv_word(3'(i));
                        end
                        r_fill  <= '0;
                        r_bits  <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_len_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LEN) |-> (r_fill == {3'b111, r_len_cnt}))
        else $error("length bytes out of step with fill count");

    a_add_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD) |-> (r_rnd == '0 && r_fill == '0))
        else $error("compression ended with rounds or block incomplete");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_xfer.load |-> !i_dq_busy)
        else $error("digest handed over while output still busy");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_fill == '0 && r_bits == '0 && r_state == ST_IDLE))
        else $error("message state not restarted after digest");
`endif

endmodule

@@ src/s256_outq.sv @@
module s256_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  s256_pkg::t_dig_xfer i_xfer,
    output logic                o_busy,
    output logic                empty,
    input  logic                pop,
    output logic [31:0]         o_digest_word,
    output logic [2:0]          o_word_index,
    output logic                o_last
);
    import s256_pkg::*;

    t_word      r_words [8];
    logic       r_valid;
    logic [2:0] r_idx;

    assign o_busy        = r_valid;
    assign empty         = !r_valid;
    assign o_digest_word = r_words[r_idx];
    assign o_word_index  = r_idx;
    assign o_last        = (r_idx == LAST_WORD);

    always_ff @(posedge i_clk) begin
        if (i_xfer.load) begin
            for (int i = 0; i < 8; i++) begin
                r_words[i] <= i_xfer.words[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_xfer.load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (pop && r_valid) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx == LAST_WORD) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

@@ src/sha256_byte_stream_hasher.sv @@
// Channel   Direction  Handshake          Payload
// input     in         push / full        i_kind, i_data_byte
// digest    out        empty / pop        o_digest_word, o_word_index, o_last
//
// A data byte shifts straight into the block; every 64th byte also starts a compression
// (64 rounds on the single round unit, then one chaining add).
// A finish shifts in 0x80, zero padding (up to 63 bytes, one a cycle outside compression)
// and the length, then one or two compressions and a handover; words drain one per pop.
// Reset (synchronous, active low) loads the initial hash values and empties both queues.
// The input queue keeps taking requests, until full, while the engine compresses; a digest
// waiting to be popped holds the engine only at the next finish.
module sha256_byte_stream_hasher #(
    parameter int unsigned QDEPTH = s256_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last
);
    import s256_pkg::*;

    t_item     w_in_item;
    t_item     w_q_item;
    logic      w_q_valid;
    logic      w_take;
    logic      w_dq_busy;
    t_dig_xfer w_xfer;

    assign w_in_item.kind      = i_kind;
    assign w_in_item.data_byte = i_data_byte;

    // front: hold incoming requests while the engine is busy compressing
    s256_front #(
        .DEPTH(QDEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (w_in_item),
        .o_valid (w_q_valid),
        .i_take  (w_take),
        .o_item  (w_q_item)
    );

    // back: block assembly, padding and the 64-round compression
    s256_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_q_valid),
        .i_item    (w_q_item),
        .o_take    (w_take),
        .i_dq_busy (w_dq_busy),
        .o_xfer    (w_xfer)
    );

    // digest register: advance one word per pop, drop after the last
    s256_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_xfer        (w_xfer),
        .o_busy        (w_dq_busy),
        .empty         (empty),
        .pop           (pop),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last        (o_last)
    );

endmodule
